FILE: hdl/ts_av_pid_finder_macros.svh
//------------------------------------------------------------------------------
// ts_av_pid_finder_macros.svh
// Assertion macros shared by the checker of the PID finder.
//------------------------------------------------------------------------------
`ifndef TS_AV_PID_FINDER_MACROS_SVH
`define TS_AV_PID_FINDER_MACROS_SVH

// Implication that is checked only while out of reset.
`define TSAV_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("tsav assertion failed");

// Next-cycle implication that is checked only while out of reset.
`define TSAV_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("tsav assertion failed");

// Next-cycle implication that is checked in reset as well.
`define TSAV_ASSERT_RST(label, pre, post) \
    label: assert property (@(posedge aclk) (pre) |=> (post)) \
        else $error("tsav assertion failed");

`endif

FILE: hdl/tsav_pkg.sv
//------------------------------------------------------------------------------
// tsav_pkg
// Constants and types of the transport stream audio/video PID finder.
//------------------------------------------------------------------------------
`default_nettype none

package tsav_pkg;

    localparam int PACKET_BYTES = 188;

    localparam int POS_W = 8;
    localparam int SID_POS_W = 9;
    localparam int PID_W = 13;
    localparam int DATA_W = 8;
    localparam int RESULT_W = 2 * PID_W + 3;
    localparam int RESULT_BYTES_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [DATA_W-1:0] SYNC_BYTE = 8'h47;
    localparam logic [DATA_W-1:0] MASK_UNIT_START = 8'h40;
    localparam logic [DATA_W-1:0] MASK_ADAPTATION = 8'h20;
    localparam logic [DATA_W-1:0] MASK_PID_HIGH = 8'h1F;

    localparam logic [DATA_W-1:0] SID_PRIVATE_1 = 8'hBD;
    localparam logic [DATA_W-1:0] SID_AUDIO_LO = 8'hC0;
    localparam logic [DATA_W-1:0] SID_AUDIO_HI = 8'hDF;
    localparam logic [DATA_W-1:0] SID_VIDEO_LO = 8'hE0;
    localparam logic [DATA_W-1:0] SID_VIDEO_HI = 8'hEF;

    // Byte positions within a packet header (sync byte at position zero).
    localparam logic [POS_W-1:0] POS_PID_HIGH = 8'd1;
    localparam logic [POS_W-1:0] POS_PID_LOW = 8'd2;
    localparam logic [POS_W-1:0] POS_ADAPT_CTRL = 8'd3;
    localparam logic [POS_W-1:0] POS_ADAPT_LEN = 8'd4;
    localparam logic [POS_W-1:0] POS_FIRST_PAYLOAD = 8'd5;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PACKET_BYTES - 1);

    localparam logic [SID_POS_W-1:0] SID_POS_DEFAULT = 9'd7;
    localparam logic [SID_POS_W-1:0] SID_POS_ADAPT_BASE = 9'd8;
    localparam logic [SID_POS_W-1:0] SID_POS_LIMIT = SID_POS_W'(PACKET_BYTES);

    typedef struct packed {
        logic             audio_is_ac3;
        logic             audio_found;
        logic [PID_W-1:0] audio_pid;
        logic             video_found;
        logic [PID_W-1:0] video_pid;
    } tsav_result_t;

endpackage

`default_nettype wire

FILE: hdl/tsav_scan.sv
//------------------------------------------------------------------------------
// tsav_scan
// Packet tracker and stream-id classifier; one byte per step.
//------------------------------------------------------------------------------
`default_nettype none

module tsav_scan (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         step,
    input  wire logic [tsav_pkg::DATA_W-1:0]  data_byte,
    input  wire logic                         last_byte,
    output tsav_pkg::tsav_result_t            result
);
    import tsav_pkg::*;

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 in_pkt_reg, in_pkt_next;
    logic                 unit_start_reg, unit_start_next;
    logic [PID_W-1:0]     pid_reg, pid_next;
    logic                 adapt_reg, adapt_next;
    logic [SID_POS_W-1:0] sid_pos_reg, sid_pos_next;
    logic [PID_W-1:0]     vpid_reg, vpid_next;
    logic [PID_W-1:0]     apid_reg, apid_next;
    logic                 vf_reg, vf_next;
    logic                 af_reg, af_next;
    logic                 ac3_reg, ac3_next;

    always_comb begin
        pos_next        = pos_reg;
        in_pkt_next     = in_pkt_reg;
        unit_start_next = unit_start_reg;
        pid_next        = pid_reg;
        adapt_next      = adapt_reg;
        sid_pos_next    = sid_pos_reg;
        vpid_next       = vpid_reg;
        apid_next       = apid_reg;
        vf_next         = vf_reg;
        af_next         = af_reg;
        ac3_next        = ac3_reg;

        if (!in_pkt_reg) begin
            if (data_byte == SYNC_BYTE) begin
                in_pkt_next     = 1'b1;
                pos_next        = '0;
                unit_start_next = 1'b0;
                adapt_next      = 1'b0;
                sid_pos_next    = SID_POS_DEFAULT;
            end
        end else begin
            pos_next = pos_reg + 1'b1;
            case (pos_next)
                POS_PID_HIGH: begin
                    unit_start_next = |(data_byte & MASK_UNIT_START);
                    pid_next = {data_byte[4:0], 8'h00};
                end
                POS_PID_LOW: begin
                    pid_next = {pid_reg[PID_W-1:DATA_W], data_byte};
                end
                POS_ADAPT_CTRL: begin
                    adapt_next   = |(data_byte & MASK_ADAPTATION);
                    sid_pos_next = SID_POS_DEFAULT;
                end
                POS_ADAPT_LEN: begin
                    if (adapt_reg) begin
                        sid_pos_next = {1'b0, data_byte} + SID_POS_ADAPT_BASE;
                    end
                end
                default: ;
            endcase

            // Classify on the stream-id byte, unless both streams are known.
            if (unit_start_next && pos_next >= POS_FIRST_PAYLOAD &&
                {1'b0, pos_next} == sid_pos_next && sid_pos_next < SID_POS_LIMIT &&
                !(vf_reg && af_reg)) begin
                if (data_byte inside {[SID_VIDEO_LO:SID_VIDEO_HI]}) begin
                    vpid_next = pid_next;
                    vf_next   = 1'b1;
                end else if (data_byte inside {[SID_AUDIO_LO:SID_AUDIO_HI]}) begin
                    apid_next = pid_next;
                    af_next   = 1'b1;
                    ac3_next  = 1'b0;
                end else if (data_byte == SID_PRIVATE_1) begin
                    apid_next = pid_next;
                    af_next   = 1'b1;
                    ac3_next  = 1'b1;
                end
            end

            if (pos_next >= POS_LAST) begin
                in_pkt_next = 1'b0;
            end
        end
    end

    always_comb begin
        result.video_pid    = vf_next ? vpid_next : '0;
        result.video_found  = vf_next;
        result.audio_pid    = af_next ? apid_next : '0;
        result.audio_found  = af_next;
        result.audio_is_ac3 = af_next & ac3_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_byte)) begin
            pos_reg        <= '0;
            in_pkt_reg     <= 1'b0;
            unit_start_reg <= 1'b0;
            pid_reg        <= '0;
            adapt_reg      <= 1'b0;
            sid_pos_reg    <= SID_POS_DEFAULT;
            vpid_reg       <= '0;
            apid_reg       <= '0;
            vf_reg         <= 1'b0;
            af_reg         <= 1'b0;
            ac3_reg        <= 1'b0;
        end else if (step) begin
            pos_reg        <= pos_next;
            in_pkt_reg     <= in_pkt_next;
            unit_start_reg <= unit_start_next;
            pid_reg        <= pid_next;
            adapt_reg      <= adapt_next;
            sid_pos_reg    <= sid_pos_next;
            vpid_reg       <= vpid_next;
            apid_reg       <= apid_next;
            vf_reg         <= vf_next;
            af_reg         <= af_next;
            ac3_reg        <= ac3_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ts_av_pid_finder.sv
//------------------------------------------------------------------------------
// ts_av_pid_finder
// Finds the video and audio PIDs in an MPEG-2 transport stream byte stream.
//------------------------------------------------------------------------------
// The block takes one transport stream byte per item and accepts a new item
// in every cycle unless a buffer end is being held back. It hunts for the
// sync byte, follows each packet of PACKET_BYTES bytes and, in packets that
// open a PES unit, reads the stream-id byte (skipping any adaptation field)
// to classify the packet's PID as video, MPEG audio or private stream 1
// (AC-3) audio. Later hits replace earlier ones until both a video and an
// audio PID are known. The item flagged with tlast ends the buffer: after it
// has been scanned, one result item carrying the found PIDs and flags is
// issued and the search starts afresh. An item passes through an input
// register and the scanner into the result register, which takes a buffer's
// result as the buffer's last byte leaves the input register. Only an item
// with tlast can be held back, and only while a previous result is still
// waiting to be taken; every other byte flows through at one item per cycle.
`default_nettype none

module ts_av_pid_finder (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input stream.
    input  wire logic                                s_axis_tvalid,
    output      logic                                s_axis_tready,
    input  wire logic [tsav_pkg::DATA_W-1:0]         s_axis_tdata, // [7:0] data_byte
    input  wire logic                                s_axis_tlast, // last_byte
    // Result stream.
    output      logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [12:0] video_pid, [13] video_found, [26:14] audio_pid, [27] audio_found,
    // [28] audio_is_ac3, [31:29] zero
    output      logic [tsav_pkg::RESULT_BYTES_W-1:0] m_axis_tdata
);
    import tsav_pkg::*;

    logic              s1_valid_reg;
    logic [DATA_W-1:0] s1_data_reg;
    logic              s1_last_reg;
    logic              out_valid_reg;
    tsav_result_t      out_data_reg;
    tsav_result_t      scan_result;
    logic              out_free;
    logic              s1_fire;
    logic              in_accept;

    // The result register can take a new result when empty or being drained.
    assign out_free  = !out_valid_reg || m_axis_tready;
    // A plain byte always moves on; the buffer's last byte needs a free result slot.
    assign s1_fire   = s1_valid_reg && (!s1_last_reg || out_free);
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_data_reg <= s_axis_tdata;
            s1_last_reg <= s_axis_tlast;
        end
    end

    tsav_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (s1_fire),
        .data_byte (s1_data_reg),
        .last_byte (s1_last_reg),
        .result    (scan_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_fire && s1_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_last_reg) begin
            out_data_reg <= scan_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(RESULT_BYTES_W - RESULT_W){1'b0}}, out_data_reg};

endmodule

`default_nettype wire

FILE: hdl/tsav_checker.sv
//------------------------------------------------------------------------------
// tsav_checker
// Port-level assertions for the PID finder, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

`include "ts_av_pid_finder_macros.svh"

module tsav_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_axis_tready,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [tsav_pkg::RESULT_BYTES_W-1:0] m_axis_tdata
);
    import tsav_pkg::*;

    // No result is shown in the cycle after reset.
    `TSAV_ASSERT_RST(a_reset_clears_result, !aresetn, !m_axis_tvalid)
    // A waiting result is not withdrawn.
    `TSAV_ASSERT_NXT(a_result_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // The input is only held off while a result waits and is not being taken.
    `TSAV_ASSERT_IMP(a_ready_when_free, !m_axis_tvalid || m_axis_tready, s_axis_tready)
    // A video PID is reported only together with its flag.
    `TSAV_ASSERT_IMP(a_video_pid_flag, m_axis_tvalid && !m_axis_tdata[13], m_axis_tdata[12:0] == '0)
    // Audio PID and the AC-3 flag are reported only together with the audio flag.
    `TSAV_ASSERT_IMP(a_audio_pid_flag, m_axis_tvalid && !m_axis_tdata[27], m_axis_tdata[26:14] == '0 && !m_axis_tdata[28])

endmodule

bind ts_av_pid_finder tsav_checker u_tsav_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: tb/sv/ts_av_pid_finder_tb.sv
//------------------------------------------------------------------------------
// ts_av_pid_finder_tb
// Self-checking testbench for the transport stream audio/video PID finder.
//------------------------------------------------------------------------------
// Transport stream bytes are sent into the block as items, one buffer after
// another, with the final byte of each buffer flagged by tlast. A behavioural
// tracker inside the testbench follows every accepted item in the same way as
// the block should (sync hunt, header decode, adaptation field skip, stream-id
// classification, freezing once both streams are known) and queues the report
// that each buffer should produce. Every report item that leaves the block is
// compared field by field with the oldest queued report.
//
// The stimulus opens with a few hand-made buffers, then covers the end of the
// packet, the freeze once both PIDs are known and a long stall on the result
// side, and finishes with a batch of random buffers: mostly truncated
// packets whose stream-id byte is reached, some runs of whole packets with
// adaptation fields of any length, and some plain noise.
//------------------------------------------------------------------------------

module ts_av_pid_finder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsav_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int RESET_CYCLES = 11;
    // The last byte passes the input register, the report the result register; allow a margin.
    localparam int DRAIN_CYCLES = 10;
    // Roughly 1800 items, plus stalls, many times over.
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PACKET_ITEMS = 320;
    localparam int RANDOM_REPORTS = 8;

    typedef enum int {BUF_SHORT, BUF_RUN, BUF_NOISE} buffer_kind_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [DATA_W-1:0]         s_axis_tdata;   // [7:0] data_byte
    logic                      s_axis_tlast;   // last_byte
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    // [12:0] video_pid, [13] video_found, [26:14] audio_pid, [27] audio_found,
    // [28] audio_is_ac3, [31:29] zero
    logic [RESULT_BYTES_W-1:0] m_axis_tdata;

    ts_av_pid_finder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Reports that the tracker has worked out and the block still owes.
    tsav_result_t reports_due[$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned packet_items_sent = 0;
    int unsigned reports_predicted = 0;

    // Idling switches for the two sides, and a one-off long hold on the result side.
    bit          send_gaps = 1'b1;
    bit          take_gaps = 1'b1;
    int unsigned hold_off_request = 0;

    // Tracker state: where we are in the stream and what has been found so far.
    logic [POS_W-1:0]     trk_pos;
    logic                 trk_in_packet;
    logic                 trk_unit_start;
    logic                 trk_adapt;
    logic [PID_W-1:0]     trk_pid;
    logic [SID_POS_W-1:0] trk_sid_pos;
    logic [PID_W-1:0]     hit_video_pid;
    logic [PID_W-1:0]     hit_audio_pid;
    logic                 hit_video;
    logic                 hit_audio;
    logic                 hit_ac3;

    //--------------------------------------------------------------------------
    // Tracker
    //--------------------------------------------------------------------------

    // Back to the state after reset: hunting for sync with nothing found.
    function automatic void clear_search();
        trk_pos = '0;
        trk_in_packet = 1'b0;
        trk_unit_start = 1'b0;
        trk_adapt = 1'b0;
        trk_pid = '0;
        trk_sid_pos = SID_POS_DEFAULT;
        hit_video_pid = '0;
        hit_audio_pid = '0;
        hit_video = 1'b0;
        hit_audio = 1'b0;
        hit_ac3 = 1'b0;
    endfunction

    // Follows one accepted byte. The byte that closes a buffer is scanned in
    // full first; only then is the report formed and the search cleared.
    function automatic void track_stream_byte(input logic [DATA_W-1:0] b, input logic last);
        tsav_result_t rep;
        if (!trk_in_packet) begin
            if (b == SYNC_BYTE) begin
                trk_in_packet = 1'b1;
                trk_pos = '0;
                trk_unit_start = 1'b0;
                trk_adapt = 1'b0;
                trk_sid_pos = SID_POS_DEFAULT;
            end
        end else begin
            trk_pos = trk_pos + 1'b1;
            case (trk_pos)
                POS_PID_HIGH: begin
                    trk_unit_start = |(b & MASK_UNIT_START);
                    trk_pid = {b[4:0] & MASK_PID_HIGH[4:0], 8'h00};
                end
                POS_PID_LOW: begin
                    trk_pid[7:0] = b;
                end
                POS_ADAPT_CTRL: begin
                    trk_adapt = |(b & MASK_ADAPTATION);
                    trk_sid_pos = SID_POS_DEFAULT;
                end
                POS_ADAPT_LEN: begin
                    // The stream-id sits four bytes past the end of the adaptation field.
                    if (trk_adapt)
                        trk_sid_pos = SID_POS_W'(b) + SID_POS_ADAPT_BASE;
                end
                default: ;
            endcase
            // A stream-id position past the end of the packet is never read.
            // Once both streams are known nothing changes until the report.
            if (trk_unit_start && trk_pos >= POS_FIRST_PAYLOAD &&
                SID_POS_W'(trk_pos) == trk_sid_pos && trk_sid_pos < SID_POS_LIMIT &&
                !(hit_video && hit_audio)) begin
                if (b >= SID_VIDEO_LO && b <= SID_VIDEO_HI) begin
                    hit_video_pid = trk_pid;
                    hit_video = 1'b1;
                end else if (b >= SID_AUDIO_LO && b <= SID_AUDIO_HI) begin
                    hit_audio_pid = trk_pid;
                    hit_audio = 1'b1;
                    hit_ac3 = 1'b0;
                end else if (b == SID_PRIVATE_1) begin
                    hit_audio_pid = trk_pid;
                    hit_audio = 1'b1;
                    hit_ac3 = 1'b1;
                end
            end
            // After the final packet byte the hunt resumes with the very next byte.
            if (trk_pos >= POS_LAST)
                trk_in_packet = 1'b0;
        end
        if (last) begin
            rep.video_pid = hit_video ? hit_video_pid : '0;
            rep.video_found = hit_video;
            rep.audio_pid = hit_audio ? hit_audio_pid : '0;
            rep.audio_found = hit_audio;
            rep.audio_is_ac3 = hit_audio & hit_ac3;
            reports_due.push_back(rep);
            reports_predicted++;
            clear_search();
        end
    endfunction

    //--------------------------------------------------------------------------
    // Clock, cycle limit, result side and checking
    //--------------------------------------------------------------------------

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // A hung handshake or a report that never comes ends here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("ts_av_pid_finder_tb: done, errors");
        $finish;
    end

    // The receiver draws a wait before each report item. When a long hold is
    // requested it keeps tready low for that many cycles instead, so that the
    // block has to hold back the next buffer end while the sender keeps going.
    initial begin
        int unsigned wait_cycles;
        m_axis_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_off_request != 0) begin
                wait_cycles = hold_off_request;
                hold_off_request = 0;
            end else begin
                wait_cycles = take_gaps ? $urandom_range(0, 9) : 0;
            end
            @(negedge aclk);
            if (wait_cycles != 0) begin
                m_axis_tready = 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            m_axis_tready = 1'b1;
            do @(posedge aclk); while (m_axis_tvalid !== 1'b1);
        end
    end

    // Every report item taken by the receiver is matched against the oldest
    // report still owed.
    initial begin
        tsav_result_t                       got;
        tsav_result_t                       want;
        logic [RESULT_BYTES_W-RESULT_W-1:0] pad;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
                got = m_axis_tdata[RESULT_W-1:0];
                pad = m_axis_tdata[RESULT_BYTES_W-1:RESULT_W];
                if (reports_due.size() == 0) begin
                    $error("report item with none expected: tdata %h", m_axis_tdata);
                    error_count++;
                end else begin
                    want = reports_due.pop_front();
                    if (got.video_pid !== want.video_pid) begin
                        $error("video_pid: expected %h, got %h", want.video_pid, got.video_pid);
                        error_count++;
                    end
                    if (got.video_found !== want.video_found) begin
                        $error("video_found: expected %b, got %b",
                               want.video_found, got.video_found);
                        error_count++;
                    end
                    if (got.audio_pid !== want.audio_pid) begin
                        $error("audio_pid: expected %h, got %h", want.audio_pid, got.audio_pid);
                        error_count++;
                    end
                    if (got.audio_found !== want.audio_found) begin
                        $error("audio_found: expected %b, got %b",
                               want.audio_found, got.audio_found);
                        error_count++;
                    end
                    if (got.audio_is_ac3 !== want.audio_is_ac3) begin
                        $error("audio_is_ac3: expected %b, got %b",
                               want.audio_is_ac3, got.audio_is_ac3);
                        error_count++;
                    end
                    if (pad !== '0) begin
                        $error("tdata padding: expected 0, got %h", pad);
                        error_count++;
                    end
                end
            end
        end
    end

    //--------------------------------------------------------------------------
    // Stimulus helpers
    //--------------------------------------------------------------------------

    // Offers one byte from the falling edge on and returns at the rising edge
    // that accepts it. With no gap drawn, tvalid simply stays high.
    task automatic send_byte(input logic [DATA_W-1:0] b, input logic last);
        int unsigned gap;
        gap = send_gaps ? $urandom_range(0, 9) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata = b;
        s_axis_tlast = last;
        s_axis_tvalid = 1'b1;
        do @(posedge aclk); while (s_axis_tready !== 1'b1);
        track_stream_byte(b, last);
    endtask

    // Sends the first len bytes of a packet. Header bits not under test and
    // the payload are random; the stream-id byte is placed only if it falls
    // within the bytes sent, so a short len gives a truncated packet.
    task automatic send_packet(input logic [PID_W-1:0] pid, input bit unit_start,
                               input bit adapt, input logic [7:0] adapt_len,
                               input logic [7:0] stream_id, input int unsigned len,
                               input bit ends_buffer);
        int unsigned      sid_at;
        int unsigned      p;
        logic [DATA_W-1:0] b;
        sid_at = adapt ? adapt_len + 8 : 7;
        for (p = 0; p < len; p++) begin
            b = DATA_W'($urandom);
            case (p)
                0: b = SYNC_BYTE;
                1: b = {b[7], unit_start, b[5], pid[12:8]};
                2: b = pid[7:0];
                3: b[5] = adapt;
                4: if (adapt) b = adapt_len;
                default: if (p == sid_at) b = stream_id;
            endcase
            packet_items_sent++;
            send_byte(b, ends_buffer && p == len - 1);
        end
    endtask

    // Random bytes; a stray sync byte among them just opens a packet.
    task automatic send_noise(input int unsigned n, input bit ends_buffer);
        int unsigned k;
        for (k = 0; k < n; k++)
            send_byte(DATA_W'($urandom), ends_buffer && k == n - 1);
    endtask

    function automatic logic [PID_W-1:0] pick_pid();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return PID_W'($urandom);
        endcase
    endfunction

    // Mostly stream-ids that classify, across the whole of each range.
    function automatic logic [7:0] pick_stream_id();
        case ($urandom_range(0, 9))
            0, 1, 2: return SID_VIDEO_LO + 8'($urandom_range(0, 15));
            3, 4: return SID_AUDIO_LO + 8'($urandom_range(0, 31));
            5: return SID_PRIVATE_1;
            default: return 8'($urandom);
        endcase
    endfunction

    //--------------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------------

    // Hand-made buffers: header field extremes and each classification.
    task automatic test_directed();
        // A buffer that is nothing but a sync byte finds nothing.
        send_byte(SYNC_BYTE, 1'b1);
        // Video at the highest PID; the stream-id byte also closes the buffer.
        send_packet('1, 1'b1, 1'b0, 8'h00, SID_VIDEO_HI, 8, 1'b1);
        // Private stream 1 at PID zero behind an empty adaptation field.
        send_packet('0, 1'b1, 1'b1, 8'h00, SID_PRIVATE_1, 9, 1'b1);
        // Without payload-unit-start the stream-id byte is not looked at.
        send_packet(pick_pid(), 1'b0, 1'b0, 8'h00, SID_VIDEO_LO, 8, 1'b1);
        // MPEG audio at the top of its range.
        send_packet(pick_pid(), 1'b1, 1'b0, 8'h00, SID_AUDIO_HI, 8, 1'b1);
        // A lone byte of all ones.
        send_byte(8'hFF, 1'b1);
    endtask

    // Stream-id positions at and beyond the last byte of the packet.
    task automatic test_packet_end();
        // The last byte of the packet is still read as the stream-id.
        send_packet(pick_pid(), 1'b1, 1'b1, 8'd179, SID_VIDEO_LO, PACKET_BYTES, 1'b1);
        // One further on lies outside the packet; the following packet, which
        // comes straight after, must not supply it.
        send_packet(pick_pid(), 1'b1, 1'b1, 8'd180, SID_AUDIO_LO, PACKET_BYTES, 1'b0);
        send_packet(pick_pid(), 1'b0, 1'b0, 8'h00, SID_VIDEO_LO, 8, 1'b1);
        // The longest adaptation field points far past the end.
        send_packet(pick_pid(), 1'b1, 1'b1, 8'hFF, SID_PRIVATE_1, PACKET_BYTES, 1'b1);
    endtask

    // Once video and audio are both known, later hits leave the report alone.
    task automatic test_freeze_after_both();
        send_packet(pick_pid(), 1'b1, 1'b0, 8'h00, SID_VIDEO_LO, PACKET_BYTES, 1'b0);
        send_noise(2, 1'b0);
        send_packet(pick_pid(), 1'b1, 1'b1, 8'd3, SID_PRIVATE_1, PACKET_BYTES, 1'b0);
        send_packet(pick_pid(), 1'b1, 1'b0, 8'h00, SID_AUDIO_LO, PACKET_BYTES, 1'b0);
        send_packet(pick_pid(), 1'b1, 1'b0, 8'h00, SID_VIDEO_HI, 12, 1'b1);
    endtask

    // The receiver stops for a long while; short buffers keep coming with no
    // gaps, so the block has to hold back a buffer end and stall its input.
    task automatic test_input_stall();
        int unsigned k;
        hold_off_request = HOLD_OFF_CYCLES;
        send_gaps = 1'b0;
        for (k = 0; k < 24; k++)
            send_packet(pick_pid(), 1'b1, 1'b0, 8'h00, pick_stream_id(), 8, 1'b1);
        send_gaps = 1'b1;
    endtask

    // Random buffers until enough packet bytes and reports have gone through.
    task automatic test_random_buffers();
        int unsigned  start_items;
        int unsigned  start_reports;
        int unsigned  pick;
        int unsigned  sid_at;
        int unsigned  len;
        int unsigned  n_packets;
        int unsigned  k;
        bit           adapt;
        bit           quiet;
        logic [7:0]   adapt_len;
        buffer_kind_t kind;
        start_items = packet_items_sent;
        start_reports = reports_predicted;
        while (packet_items_sent - start_items < RANDOM_PACKET_ITEMS ||
               reports_predicted - start_reports < RANDOM_REPORTS) begin
            // Now and then a buffer runs with no idling on either side.
            quiet = ($urandom_range(0, 4) == 0);
            send_gaps = !quiet;
            take_gaps = !quiet;
            pick = $urandom_range(0, 9);
            kind = (pick < 6) ? BUF_SHORT : (pick < 8) ? BUF_RUN : BUF_NOISE;
            case (kind)
                BUF_SHORT: begin
                    // One packet cut off a little after its stream-id, or now
                    // and then before it, sometimes after a little noise.
                    if ($urandom_range(0, 3) == 0)
                        send_noise($urandom_range(1, 3), 1'b0);
                    adapt = ($urandom_range(0, 3) == 0);
                    adapt_len = 8'($urandom_range(0, 12));
                    sid_at = adapt ? adapt_len + 8 : 7;
                    len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, sid_at)
                                                      : sid_at + 1 + $urandom_range(0, 6);
                    send_packet(pick_pid(), $urandom_range(0, 7) != 0, adapt, adapt_len,
                                pick_stream_id(), len, 1'b1);
                end
                BUF_RUN: begin
                    // Whole packets back to back or with noise between them;
                    // the final one may be cut short.
                    n_packets = $urandom_range(1, 2);
                    for (k = 0; k < n_packets; k++) begin
                        adapt = ($urandom_range(0, 2) == 0);
                        adapt_len = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 12));
                        len = (k == n_packets - 1) ? $urandom_range(1, PACKET_BYTES)
                                                   : PACKET_BYTES;
                        send_packet(pick_pid(), $urandom_range(0, 5) != 0, adapt, adapt_len,
                                    pick_stream_id(), len, k == n_packets - 1);
                        if (k != n_packets - 1 && $urandom_range(0, 2) == 0)
                            send_noise($urandom_range(1, 3), 1'b0);
                    end
                end
                BUF_NOISE: begin
                    send_noise($urandom_range(1, 20), 1'b1);
                end
            endcase
        end
        send_gaps = 1'b1;
        take_gaps = 1'b1;
    endtask

    //--------------------------------------------------------------------------
    // Sequence
    //--------------------------------------------------------------------------

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        clear_search();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_packet_end();
        test_freeze_after_both();
        test_input_stall();
        test_random_buffers();

        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        s_axis_tlast = 1'b0;
        // Wait for every owed report, then a drain margin for anything stray.
        while (reports_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("ts_av_pid_finder_tb: done, clean");
        else
            $display("ts_av_pid_finder_tb: done, errors");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/tsav_pkg.sv
hdl/tsav_scan.sv
hdl/ts_av_pid_finder.sv
hdl/tsav_checker.sv
tb/sv/ts_av_pid_finder_tb.sv
